// ----- hw/rtl/pbrd_pkg.sv -----
// Shared types and constants of the pulse beat-rate detector.
package pbrd_pkg;

    // Field widths
    localparam int SAMPLE_W  = 12;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int BASE_W    = 28;
    localparam int AC_W      = 13;
    localparam int DERIV_W   = 14;
    localparam int SQ_W      = 27;
    localparam int ENV_W     = 26;
    localparam int LVL_W     = 35;
    localparam int BPM_W     = 10;
    localparam int DT_W      = 16;
    localparam int RATE_NUM_W = 18;
    localparam int DIV_DEN_W  = 17;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE_ALPHA   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_DECAY       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_DECAY      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_FACTOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_BEAT_MS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BEAT_MS      = 3'd5;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_BASELINE_ALPHA   = 16'd65208;
    localparam logic [CFG_W-1:0] RST_PEAK_DECAY       = 16'd65470;
    localparam logic [CFG_W-1:0] RST_NOISE_DECAY      = 16'd65470;
    localparam logic [CFG_W-1:0] RST_THRESHOLD_FACTOR = 16'd32768;
    localparam logic [CFG_W-1:0] RST_MIN_BEAT_MS      = 16'd300;
    localparam logic [CFG_W-1:0] RST_MAX_BEAT_MS      = 16'd2000;

    // Arithmetic constants
    localparam logic [15:0]           ROUND_HALF = 16'h8000;
    localparam logic [16:0]           Q16_ONE    = 17'h10000;
    localparam logic [RATE_NUM_W-1:0] RATE_NUM   = 18'd120000;
    localparam logic [BPM_W-1:0]      BPM_MAX    = 10'd1000;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic base;
        logic diff;
        logic sq;
        logic env;
        logic track;
        logic thr;
        logic det;
        logic rate_go;
        logic rate_wait;
        logic hist;
        logic avg_go;
        logic avg_wait;
        logic out_load;
    } pbrd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
        logic rate_ok;
    } pbrd_status_t;

endpackage

// ----- hw/rtl/pbrd_in_if.sv -----
// Input channel: one pulse sample with its timestamp.
interface pbrd_in_if;
    logic                          valid;
    logic                          ready;
    logic [pbrd_pkg::SAMPLE_W-1:0] sample;
    logic [pbrd_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, output sample, output now_ms, input ready);
    modport sink   (input valid, input sample, input now_ms, output ready);
endinterface

// ----- hw/rtl/pbrd_out_if.sv -----
// Output channel: one detector result per sample.
interface pbrd_out_if;
    logic                       valid;
    logic                       ready;
    logic                       beat;
    logic                       above;
    logic [pbrd_pkg::ENV_W-1:0] envelope;
    logic [pbrd_pkg::ENV_W-1:0] threshold;
    logic [pbrd_pkg::BPM_W-1:0] bpm;

    modport source (output valid, output beat, output above, output envelope,
                    output threshold, output bpm, input ready);
    modport sink   (input valid, input beat, input above, input envelope,
                    input threshold, input bpm, output ready);
endinterface

// ----- hw/rtl/pbrd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pbrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ----- hw/rtl/pbrd_div.sv -----
// Restoring divider, one quotient bit per cycle.
module pbrd_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 17
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             fits;

    // Trial subtraction of one step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        trial_sub = trial - {1'b0, den_reg};
        fits      = (trial >= {1'b0, den_reg});
    end

    // Step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift the dividend through the partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ----- hw/rtl/pbrd_datapath.sv -----
// Datapath: filter, envelope, level trackers, beat timing and rate history.
module pbrd_datapath #(
    parameter int WINDOW_LEN  = 32,
    parameter int HISTORY_LEN = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [pbrd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pbrd_pkg::CFG_W-1:0]     cfg_data,
    input  logic [pbrd_pkg::SAMPLE_W-1:0]  in_sample,
    input  logic [pbrd_pkg::TIME_W-1:0]    in_now_ms,
    input  pbrd_pkg::pbrd_cmd_t            cmd,
    output pbrd_pkg::pbrd_status_t         status,
    output logic                           out_beat,
    output logic                           out_above,
    output logic [pbrd_pkg::ENV_W-1:0]     out_envelope,
    output logic [pbrd_pkg::ENV_W-1:0]     out_threshold,
    output logic [pbrd_pkg::BPM_W-1:0]     out_bpm
);
    localparam int SQ_W   = pbrd_pkg::SQ_W;
    localparam int LVL_W  = pbrd_pkg::LVL_W;
    localparam int SUM_W  = SQ_W + $clog2(WINDOW_LEN);
    localparam int WPOS_W = $clog2(WINDOW_LEN);
    localparam int HPOS_W = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
    localparam int CNT_W  = $clog2(HISTORY_LEN + 1);
    localparam int HSUM_W = $clog2(1000 * HISTORY_LEN + 1);
    localparam int DIV_NW = (HSUM_W > pbrd_pkg::RATE_NUM_W) ? HSUM_W : pbrd_pkg::RATE_NUM_W;
    localparam int DIV_DW = pbrd_pkg::DIV_DEN_W;

    // Configuration registers
    logic [pbrd_pkg::CFG_W-1:0] alpha_reg, pdecay_reg, ndecay_reg, tfactor_reg;
    logic [pbrd_pkg::CFG_W-1:0] min_reg, max_reg;

    // Item registers
    logic [pbrd_pkg::SAMPLE_W-1:0]     sample_reg;
    logic [pbrd_pkg::TIME_W-1:0]       now_reg;
    logic signed [pbrd_pkg::DERIV_W-1:0] deriv_reg;
    logic                              win_old_valid_reg;
    logic [pbrd_pkg::ENV_W-1:0]        env_reg;
    logic [LVL_W-1:0]                  scaled_reg;
    logic                              ge_reg;
    logic [LVL_W-1:0]                  thr_reg;
    logic                              above_reg;
    logic                              beat_reg;
    logic [pbrd_pkg::DT_W-1:0]         dt_reg;
    logic [pbrd_pkg::BPM_W-1:0]        rate_reg;

    // Persistent state
    logic [pbrd_pkg::BASE_W-1:0]       base_reg;
    logic signed [pbrd_pkg::AC_W-1:0]  prev_ac_reg;
    logic [SUM_W-1:0]                  win_sum_reg;
    logic [WPOS_W-1:0]                 win_pos_reg;
    logic [WINDOW_LEN-1:0]             win_valid_reg;
    logic [LVL_W-1:0]                  peak_reg, noise_reg;
    logic                              was_above_reg, have_prior_reg;
    logic [pbrd_pkg::TIME_W-1:0]       prior_reg, last_det_reg;
    logic [HPOS_W-1:0]                 hist_pos_reg;
    logic [CNT_W-1:0]                  hist_cnt_reg;
    logic [HSUM_W-1:0]                 hist_sum_reg;
    logic [pbrd_pkg::BPM_W-1:0]        bpm_reg;

    // Output payload registers
    logic                              obeat_reg, oabove_reg;
    logic [pbrd_pkg::ENV_W-1:0]        oenv_reg, othr_reg;
    logic [pbrd_pkg::BPM_W-1:0]        obpm_reg;

    // Combinational values
    logic [43:0]                       base_old_prod;
    logic [16:0]                       inv_alpha;
    logic [28:0]                       base_new_prod;
    logic [45:0]                       base_sum;
    logic [28:0]                       rnd_sum;
    logic [13:0]                       ac_wide;
    logic signed [pbrd_pkg::AC_W-1:0]  ac;
    logic signed [pbrd_pkg::DERIV_W-1:0] deriv_next;
    logic signed [27:0]                sq_full;
    logic [SQ_W-1:0]                   sq;
    logic [SQ_W-1:0]                   win_rdata, win_old;
    logic [50:0]                       peak_prod, noise_prod, thr_prod;
    logic [LVL_W-1:0]                  env8, env8_half, lvl_diff;
    logic [LVL_W-1:0]                  thr_c;
    logic                              above_c, rising;
    logic [pbrd_pkg::TIME_W-1:0]       since_det, dt_full;
    logic [pbrd_pkg::BPM_W-1:0]        hist_rdata;
    logic                              div_start, div_done;
    logic [DIV_NW-1:0]                 div_num, div_q;
    logic [DIV_DW-1:0]                 div_den;
    logic [pbrd_pkg::RATE_NUM_W-1:0]   rate_num;

    // Baseline, AC part and derivative
    always_comb
    begin
        base_old_prod = 44'(alpha_reg) * 44'(base_reg);
        inv_alpha     = pbrd_pkg::Q16_ONE - {1'b0, alpha_reg};
        base_new_prod = 29'(inv_alpha) * 29'(sample_reg);
        base_sum      = {2'b0, base_old_prod} + {1'b0, base_new_prod, 16'b0}
                        + 46'(pbrd_pkg::ROUND_HALF);
        rnd_sum       = {1'b0, base_reg} + 29'(pbrd_pkg::ROUND_HALF);
        ac_wide       = {2'b0, sample_reg} - {1'b0, rnd_sum[28:16]};
        ac            = ac_wide[12:0];
        deriv_next    = {ac[12], ac} - {prev_ac_reg[12], prev_ac_reg};
        sq_full       = deriv_reg * deriv_reg;
        sq            = sq_full[SQ_W-1:0];
        win_old       = win_old_valid_reg ? win_rdata : '0;
    end

    // Level trackers, threshold and beat detection
    always_comb
    begin
        peak_prod  = 51'(peak_reg) * 51'(pdecay_reg);
        noise_prod = 51'(noise_reg) * 51'(ndecay_reg);
        env8       = {1'b0, env_reg, 8'b0};
        env8_half  = {1'b0, env8[LVL_W-1:1]};
        lvl_diff   = (peak_reg >= noise_reg) ? (peak_reg - noise_reg)
                                             : (noise_reg - peak_reg);
        thr_prod   = 51'(tfactor_reg) * 51'(lvl_diff);
        thr_c      = ge_reg ? (noise_reg + scaled_reg) : (noise_reg - scaled_reg);
        above_c    = (env8 > thr_c);
        since_det  = now_reg - last_det_reg;
        dt_full    = now_reg - prior_reg;
        rising     = above_c && !was_above_reg
                     && (since_det > {16'b0, min_reg});
        status.rate_ok = rising && have_prior_reg && (dt_full != '0)
                         && (dt_full >= {16'b0, min_reg})
                         && (dt_full <= {16'b0, max_reg});
    end

    // Share the divider between rate and average
    always_comb
    begin
        rate_num  = pbrd_pkg::RATE_NUM + {2'b0, dt_reg};
        div_start = cmd.rate_go || cmd.avg_go;
        if (cmd.rate_go)
        begin
            div_num = DIV_NW'(rate_num);
            div_den = {dt_reg, 1'b0};
        end
        else
        begin
            div_num = DIV_NW'(hist_sum_reg);
            div_den = DIV_DW'(hist_cnt_reg);
        end
        status.div_done = div_done;
    end

    pbrd_div #(
        .NUM_W (DIV_NW),
        .DEN_W (DIV_DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    pbrd_ram #(
        .WIDTH (SQ_W),
        .DEPTH (WINDOW_LEN)
    ) u_window_ram (
        .clk   (clk),
        .we    (cmd.sq),
        .waddr (win_pos_reg),
        .wdata (sq),
        .re    (cmd.base),
        .raddr (win_pos_reg),
        .rdata (win_rdata)
    );

    pbrd_ram #(
        .WIDTH (pbrd_pkg::BPM_W),
        .DEPTH (HISTORY_LEN)
    ) u_history_ram (
        .clk   (clk),
        .we    (cmd.hist),
        .waddr (hist_pos_reg),
        .wdata (rate_reg),
        .re    (cmd.base),
        .raddr (hist_pos_reg),
        .rdata (hist_rdata)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg   <= pbrd_pkg::RST_BASELINE_ALPHA;
            pdecay_reg  <= pbrd_pkg::RST_PEAK_DECAY;
            ndecay_reg  <= pbrd_pkg::RST_NOISE_DECAY;
            tfactor_reg <= pbrd_pkg::RST_THRESHOLD_FACTOR;
            min_reg     <= pbrd_pkg::RST_MIN_BEAT_MS;
            max_reg     <= pbrd_pkg::RST_MAX_BEAT_MS;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pbrd_pkg::REG_BASELINE_ALPHA:   alpha_reg   <= cfg_data;
                pbrd_pkg::REG_PEAK_DECAY:       pdecay_reg  <= cfg_data;
                pbrd_pkg::REG_NOISE_DECAY:      ndecay_reg  <= cfg_data;
                pbrd_pkg::REG_THRESHOLD_FACTOR: tfactor_reg <= cfg_data;
                pbrd_pkg::REG_MIN_BEAT_MS:      min_reg     <= cfg_data;
                pbrd_pkg::REG_MAX_BEAT_MS:      max_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Persistent detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= '0;
            prev_ac_reg    <= '0;
            win_sum_reg    <= '0;
            win_pos_reg    <= '0;
            win_valid_reg  <= '0;
            peak_reg       <= '0;
            noise_reg      <= '0;
            was_above_reg  <= 1'b0;
            have_prior_reg <= 1'b0;
            prior_reg      <= '0;
            last_det_reg   <= '0;
            hist_pos_reg   <= '0;
            hist_cnt_reg   <= '0;
            hist_sum_reg   <= '0;
            bpm_reg        <= '0;
        end
        else
        begin
            if (cmd.base)
            begin
                base_reg <= base_sum[43:16];
            end
            if (cmd.diff)
            begin
                prev_ac_reg <= ac;
                peak_reg    <= peak_prod[50:16];
                noise_reg   <= noise_prod[50:16];
            end
            // Replace the oldest square in the window
            if (cmd.sq)
            begin
                win_sum_reg <= win_sum_reg - SUM_W'(win_old) + SUM_W'(sq);
                win_valid_reg[win_pos_reg] <= 1'b1;
                win_pos_reg <= (win_pos_reg == WPOS_W'(WINDOW_LEN - 1))
                               ? '0 : win_pos_reg + WPOS_W'(1);
            end
            if (cmd.track)
            begin
                if (env8 > peak_reg)
                begin
                    peak_reg <= env8;
                end
                else if (env8_half > noise_reg)
                begin
                    noise_reg <= env8_half;
                end
            end
            if (cmd.det)
            begin
                was_above_reg <= above_c;
                if (rising)
                begin
                    last_det_reg   <= now_reg;
                    prior_reg      <= now_reg;
                    have_prior_reg <= 1'b1;
                end
            end
            // Push the new rate into the history
            if (cmd.hist)
            begin
                if (hist_cnt_reg == CNT_W'(HISTORY_LEN))
                begin
                    hist_sum_reg <= hist_sum_reg - HSUM_W'(hist_rdata) + HSUM_W'(rate_reg);
                end
                else
                begin
                    hist_sum_reg <= hist_sum_reg + HSUM_W'(rate_reg);
                    hist_cnt_reg <= hist_cnt_reg + CNT_W'(1);
                end
                hist_pos_reg <= (hist_pos_reg == HPOS_W'(HISTORY_LEN - 1))
                                ? '0 : hist_pos_reg + HPOS_W'(1);
            end
            if (cmd.avg_wait && div_done)
            begin
                bpm_reg <= div_q[pbrd_pkg::BPM_W-1:0];
            end
        end
    end

    // Per-item working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sample_reg <= in_sample;
            now_reg    <= in_now_ms;
        end
        if (cmd.base)
        begin
            win_old_valid_reg <= win_valid_reg[win_pos_reg];
        end
        if (cmd.diff)
        begin
            deriv_reg <= deriv_next;
        end
        // Window mean: WINDOW_LEN is a power of two, so drop the low sum bits
        if (cmd.env)
        begin
            env_reg <= win_sum_reg[WPOS_W +: pbrd_pkg::ENV_W];
        end
        if (cmd.thr)
        begin
            ge_reg     <= (peak_reg >= noise_reg);
            scaled_reg <= thr_prod[50:16];
        end
        if (cmd.det)
        begin
            thr_reg   <= thr_c;
            above_reg <= above_c;
            beat_reg  <= rising;
            dt_reg    <= dt_full[pbrd_pkg::DT_W-1:0];
        end
        // Saturate the instantaneous rate
        if (cmd.rate_wait && div_done)
        begin
            rate_reg <= (div_q > DIV_NW'(pbrd_pkg::BPM_MAX))
                        ? pbrd_pkg::BPM_MAX : div_q[pbrd_pkg::BPM_W-1:0];
        end
        if (cmd.out_load)
        begin
            obeat_reg  <= beat_reg;
            oabove_reg <= above_reg;
            oenv_reg   <= env_reg;
            othr_reg   <= thr_reg[33:8];
            obpm_reg   <= bpm_reg;
        end
    end

    assign out_beat      = obeat_reg;
    assign out_above     = oabove_reg;
    assign out_envelope  = oenv_reg;
    assign out_threshold = othr_reg;
    assign out_bpm       = obpm_reg;
endmodule

// ----- hw/rtl/pbrd_ctrl.sv -----
// Controller: sequences one sample through the datapath and owns the handshakes.
module pbrd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  pbrd_pkg::pbrd_status_t status,
    output pbrd_pkg::pbrd_cmd_t    cmd
);
    typedef enum logic [13:0] {
        ST_IDLE      = 14'h0001,
        ST_BASE      = 14'h0002,
        ST_DIFF      = 14'h0004,
        ST_SQ        = 14'h0008,
        ST_ENV       = 14'h0010,
        ST_TRACK     = 14'h0020,
        ST_THR       = 14'h0040,
        ST_DET       = 14'h0080,
        ST_RATE_GO   = 14'h0100,
        ST_RATE_WAIT = 14'h0200,
        ST_HIST      = 14'h0400,
        ST_AVG_GO    = 14'h0800,
        ST_AVG_WAIT  = 14'h1000,
        ST_EMIT      = 14'h2000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_free       = !out_valid_reg || out_ready;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_BASE;
                end
            end
            ST_BASE:
            begin
                cmd.base   = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = ST_ENV;
            end
            ST_ENV:
            begin
                cmd.env    = 1'b1;
                state_next = ST_TRACK;
            end
            ST_TRACK:
            begin
                cmd.track  = 1'b1;
                state_next = ST_THR;
            end
            ST_THR:
            begin
                cmd.thr    = 1'b1;
                state_next = ST_DET;
            end
            ST_DET:
            begin
                cmd.det    = 1'b1;
                state_next = status.rate_ok ? ST_RATE_GO : ST_EMIT;
            end
            ST_RATE_GO:
            begin
                cmd.rate_go = 1'b1;
                state_next  = ST_RATE_WAIT;
            end
            ST_RATE_WAIT:
            begin
                cmd.rate_wait = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_HIST;
                end
            end
            ST_HIST:
            begin
                cmd.hist   = 1'b1;
                state_next = ST_AVG_GO;
            end
            ST_AVG_GO:
            begin
                cmd.avg_go = 1'b1;
                state_next = ST_AVG_WAIT;
            end
            ST_AVG_WAIT:
            begin
                cmd.avg_wait = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // Hold the result until the output register frees up
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

// ----- hw/rtl/pulse_beat_rate_detector_top.sv -----
// Pulse beat-rate detector top level.
// Usage:
//   samples: one transaction per pulse reading (sample, now_ms); accepted when
//   valid and ready are both high. results: one transaction per sample with
//   beat, above, envelope, threshold and bpm, held until the receiver takes it.
//   cfg_write/cfg_index/cfg_data write the six 16-bit registers while idle.
//   WINDOW_LEN must be a power of two; the window mean is a shift.
// Timing:
//   An accepted sample steps through the base, diff, square, envelope, track,
//   threshold and detect states to emit, which loads its result. A sample that
//   stores a new beat rate adds two passes of the shared divider (rate and
//   average, one quotient bit per cycle) plus a history step.
//   Only one sample is in flight; the next is taken once the previous result
//   has moved into the output register, so a stalled receiver holds back at
//   most the sample after the one waiting at the output.
// Reset:
//   rst_n clears filter, window, tracker and history state and loads the
//   register defaults; the window store reads as zero until rewritten, through
//   per-entry valid bits, so no clearing pass is needed.
module pulse_beat_rate_detector_top #(
    parameter int WINDOW_LEN  = 32,
    parameter int HISTORY_LEN = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    pbrd_in_if.sink                        samples,
    pbrd_out_if.source                     results,
    input  logic                           cfg_write,
    input  logic [pbrd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pbrd_pkg::CFG_W-1:0]     cfg_data
);
    pbrd_pkg::pbrd_cmd_t    cmd;
    pbrd_pkg::pbrd_status_t status;

    pbrd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    pbrd_datapath #(
        .WINDOW_LEN  (WINDOW_LEN),
        .HISTORY_LEN (HISTORY_LEN)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_sample     (samples.sample),
        .in_now_ms     (samples.now_ms),
        .cmd           (cmd),
        .status        (status),
        .out_beat      (results.beat),
        .out_above     (results.above),
        .out_envelope  (results.envelope),
        .out_threshold (results.threshold),
        .out_bpm       (results.bpm)
    );
endmodule
